[rtl/core/sabs_pkg.sv]
// types, constants and the search microcode table for the sorted array bound search
`default_nettype none

package sabs_pkg;

  // request operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // the four searches run by a query
  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_LAST  = 2'd1,
    MODE_GE    = 2'd2,
    MODE_GT    = 2'd3
  } mode_e;

  // micro operations of the sequencer
  typedef enum logic [1:0] {
    UOP_INIT = 2'd0,
    UOP_TEST = 2'd1,
    UOP_CMP  = 2'd2,
    UOP_DONE = 2'd3
  } uop_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned MatchW = 11;
  localparam int unsigned PcW    = 4;

  localparam logic [PcW-1:0] PcStart = 4'd0;
  localparam logic [PcW-1:0] PcDone  = 4'd12;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [IdxW-1:0]   first_index;
    logic [IdxW-1:0]   last_index;
    logic              ge_valid;
    logic [IdxW-1:0]   ge_index;
    logic              gt_valid;
    logic [IdxW-1:0]   gt_index;
    logic [MatchW-1:0] match_count;
  } res_t;

  // one control word of the microprogram
  typedef struct packed {
    uop_e           uop;
    mode_e          mode;
    logic [PcW-1:0] target;
  } ctrl_t;

  // microprogram: init, test (exit jump), compare (loop jump) per search, then done
  function automatic ctrl_t ucode_rom(input logic [PcW-1:0] pc);
    ctrl_t cw;
    unique case (pc)
      4'd0:    cw = '{uop: UOP_INIT, mode: MODE_FIRST, target: 4'd1};
      4'd1:    cw = '{uop: UOP_TEST, mode: MODE_FIRST, target: 4'd3};
      4'd2:    cw = '{uop: UOP_CMP,  mode: MODE_FIRST, target: 4'd1};
      4'd3:    cw = '{uop: UOP_INIT, mode: MODE_LAST,  target: 4'd4};
      4'd4:    cw = '{uop: UOP_TEST, mode: MODE_LAST,  target: 4'd6};
      4'd5:    cw = '{uop: UOP_CMP,  mode: MODE_LAST,  target: 4'd4};
      4'd6:    cw = '{uop: UOP_INIT, mode: MODE_GE,    target: 4'd7};
      4'd7:    cw = '{uop: UOP_TEST, mode: MODE_GE,    target: 4'd9};
      4'd8:    cw = '{uop: UOP_CMP,  mode: MODE_GE,    target: 4'd7};
      4'd9:    cw = '{uop: UOP_INIT, mode: MODE_GT,    target: 4'd10};
      4'd10:   cw = '{uop: UOP_TEST, mode: MODE_GT,    target: PcDone};
      4'd11:   cw = '{uop: UOP_CMP,  mode: MODE_GT,    target: 4'd10};
      default: cw = '{uop: UOP_DONE, mode: MODE_FIRST, target: PcStart};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sabs_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module sabs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write or read one address per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

[rtl/core/sorted_array_bound_search.sv]
// top level of the sorted array bound search: store, microcoded search sequencer
//
//   port        dir  width    meaning
//   start_i     in   1        request strobe, taken when busy_o is low
//   busy_o      out  1        query in progress, no request taken
//   req_i       in   req_t    op (append, query, clear) and value
//   valid_o     out  1        result strobe, one cycle per query
//   res_o       out  res_t    found, indices, valid flags, match count
//
// append and clear leave busy_o low.
// a query runs four binary searches with a shared single-port store; each
// probe takes two steps (address issue, compare on the registered read).
// each search makes up to clog2(count)+1 probes; valid_o rises in the cycle
// after the done step.
// reset clears the entry count and the sequencer; store contents stay undefined.
// the receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module sorted_array_bound_search #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire sabs_pkg::req_t req_i,
  output logic               valid_o,
  output sabs_pkg::res_t     res_o
);

  import sabs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // sequencer and datapath registers
  logic                    busy_q, busy_d;
  logic [PcW-1:0]          pc_q, pc_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           lo_q, lo_d;
  logic [CW-1:0]           hp1_q, hp1_d;
  logic [AW-1:0]           mid_q, mid_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic                    hit_q, hit_d;
  logic [AW-1:0]           hit_idx_q, hit_idx_d;
  logic                    rvld_q [4];
  logic                    rvld_d [4];
  logic [AW-1:0]           ridx_q [4];
  logic [AW-1:0]           ridx_d [4];
  logic                    valid_q, valid_d;
  res_t                    res_q, res_d;

  ctrl_t                   ctrl;
  logic [CW:0]             mid_sum;
  logic [AW-1:0]           mid;
  logic                    probe;
  logic                    ram_we;
  logic [AW-1:0]           ram_addr;
  logic [DataW-1:0]        ram_rdata;
  logic signed [DataW-1:0] elem;
  logic                    found;
  logic [31:0]             first32, last32, ge32, gt32, cnt32;

  // element store
  sabs_ram #(
    .WIDTH(DataW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(req_i.value),
    .rdata_o(ram_rdata)
  );

  // control word and probe address
  assign ctrl    = ucode_rom(pc_q);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hp1_q} - (CW + 1)'(1);
  assign mid     = mid_sum[AW:1];
  assign probe   = lo_q < hp1_q;
  assign elem    = $signed(ram_rdata);

  // result fields, indices masked to the output widths
  assign found   = rvld_q[MODE_FIRST] & rvld_q[MODE_LAST];
  assign first32 = 32'(ridx_q[MODE_FIRST]);
  assign last32  = 32'(ridx_q[MODE_LAST]);
  assign ge32    = 32'(ridx_q[MODE_GE]);
  assign gt32    = 32'(ridx_q[MODE_GT]);
  assign cnt32   = last32 - first32 + 32'd1;

  // next state of sequencer and datapath
  always_comb begin
    busy_d    = busy_q;
    pc_d      = pc_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hp1_d     = hp1_q;
    mid_d     = mid_q;
    key_d     = key_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    rvld_d    = rvld_q;
    ridx_d    = ridx_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_addr  = mid;

    if (!busy_q) begin
      if (start_i) begin
        unique case (op_e'(req_i.op))
          OP_APPEND: begin
            if (count_q < CW'(DEPTH)) begin
              ram_we   = 1'b1;
              ram_addr = count_q[AW-1:0];
              count_d  = count_q + CW'(1);
            end
          end
          OP_QUERY: begin
            key_d  = req_i.value;
            busy_d = 1'b1;
            pc_d   = PcStart;
          end
          OP_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
    end else begin
      unique case (ctrl.uop)
        UOP_INIT: begin
          lo_d      = '0;
          hp1_d     = count_q;
          hit_d     = 1'b0;
          hit_idx_d = '0;
          pc_d      = ctrl.target;
        end
        UOP_TEST: begin
          if (probe) begin
            mid_d = mid;
            pc_d  = pc_q + PcW'(1);
          end else begin
            rvld_d[ctrl.mode] = hit_q;
            ridx_d[ctrl.mode] = hit_idx_q;
            pc_d              = ctrl.target;
          end
        end
        UOP_CMP: begin
          pc_d = ctrl.target;
          unique case (ctrl.mode)
            MODE_FIRST, MODE_LAST: begin
              priority if (elem == key_q) begin
                hit_d     = 1'b1;
                hit_idx_d = mid_q;
                if (ctrl.mode == MODE_FIRST) begin
                  hp1_d = CW'(mid_q);
                end else begin
                  lo_d = CW'(mid_q) + CW'(1);
                end
              end else if (elem < key_q) begin
                lo_d = CW'(mid_q) + CW'(1);
              end else begin
                hp1_d = CW'(mid_q);
              end
            end
            MODE_GE, MODE_GT: begin
              if ((ctrl.mode == MODE_GE) ? (elem >= key_q) : (elem > key_q)) begin
                hit_d     = 1'b1;
                hit_idx_d = mid_q;
                hp1_d     = CW'(mid_q);
              end else begin
                lo_d = CW'(mid_q) + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        UOP_DONE: begin
          res_d.found       = found;
          res_d.first_index = found ? first32[IdxW-1:0] : '0;
          res_d.last_index  = found ? last32[IdxW-1:0] : '0;
          res_d.match_count = found ? cnt32[MatchW-1:0] : '0;
          res_d.ge_valid    = rvld_q[MODE_GE];
          res_d.ge_index    = rvld_q[MODE_GE] ? ge32[IdxW-1:0] : '0;
          res_d.gt_valid    = rvld_q[MODE_GT];
          res_d.gt_index    = rvld_q[MODE_GT] ? gt32[IdxW-1:0] : '0;
          valid_d           = 1'b1;
          busy_d            = 1'b0;
          pc_d              = PcStart;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= PcStart;
      count_q <= '0;
      lo_q    <= '0;
      hp1_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      pc_q    <= pc_d;
      count_q <= count_d;
      lo_q    <= lo_d;
      hp1_q   <= hp1_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mid_q     <= mid_d;
    key_q     <= key_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    rvld_q    <= rvld_d;
    ridx_q    <= ridx_d;
    res_q     <= res_d;
  end

  assign busy_o  = busy_q;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // search window never inverts
  assert property (@(posedge clk_i) disable iff (!rst_ni) lo_q <= hp1_q)
    else $error("search window inverted");

  // result strobe only right after a finished query
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy_o && $past(busy_o))
    else $error("result strobe without finished query");

  // an accepted query starts the sequencer at the first step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.op == OP_QUERY) |=> busy_o && (pc_q == PcStart))
    else $error("query did not start sequencer");

  // sequencer stays inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni) pc_q <= PcDone)
    else $error("microprogram counter out of range");

  // entry count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

endmodule

`default_nettype wire
